### src/pfpc_pkg.sv
`timescale 1ns / 1ps

package pfpc_pkg;

   // Default values for the top-level parameters.
   localparam int ADC_BITS_DEF  = 12;
   localparam int DRIVE_MAX_DEF = 65535;

   // Fixed field widths.
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 2;
   localparam int FORCE_W    = 16;
   localparam int COEF_W     = 16;
   localparam int CNT_W      = 32;
   localparam int LOAD_W     = 18;
   localparam int DRIVE_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Largest scaled load value.
   localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};

   // Depth of the queue between the front and the back.
   localparam int QDEPTH = 2;
   localparam int QPTR_W = 1;

   // Operation codes of an input word.
   localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
   localparam logic [OP_W-1:0] OP_STOP   = 2'd2;
   localparam logic [OP_W-1:0] OP_START  = 2'd3;

   // Run status codes.
   localparam logic [STATUS_W-1:0] ST_IDLE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RUN   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_ESTOP = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_FORCE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TIME_LIMIT      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TOGGLE_INTERVAL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LOAD_SCALE      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FORCE_GAIN      = 3'd4;

   // Decoded kind of a queued word, one flag set per word.
   typedef struct packed {
      logic sample;
      logic tick;
      logic stop;
      logic start;
   } pfpc_kind_type;

endpackage

### src/pfpc_front.sv
`timescale 1ns / 1ps

module pfpc_front
   import pfpc_pkg::*;
#(
   parameter int ADC_BITS = ADC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [ADC_BITS-1:0] req_adc_sample,
   output logic                q_valid,
   output pfpc_kind_type       q_kind,
   output logic [ADC_BITS-1:0] q_adc,
   input  logic                q_pop
);

   pfpc_kind_type       kind;
   pfpc_kind_type       kind_mem_ff [QDEPTH];
   logic [ADC_BITS-1:0] adc_mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                push;

   // Decode the operation code into one flag per kind of word.
   always_comb begin
      kind = '0;
      unique case (req_operation)
         OP_SAMPLE: kind.sample = 1'b1;
         OP_TICK:   kind.tick   = 1'b1;
         OP_STOP:   kind.stop   = 1'b1;
         OP_START:  kind.start  = 1'b1;
         default:   kind        = '0;
      endcase
   end

   // The queue stalls the sender only when it is full.
   assign req_stall = (count_ff == (QPTR_W + 1)'(QDEPTH));
   assign push      = req_valid && !req_stall;

   assign q_valid = (count_ff != '0);
   assign q_kind  = kind_mem_ff[rd_ptr_ff];
   assign q_adc   = adc_mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue entries hold payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         kind_mem_ff[wr_ptr_ff] <= kind;
         adc_mem_ff[wr_ptr_ff]  <= req_adc_sample;
      end
   end

endmodule

### src/pfpc_back.sv
`timescale 1ns / 1ps

module pfpc_back
   import pfpc_pkg::*;
#(
   parameter int ADC_BITS  = ADC_BITS_DEF,
   parameter int DRIVE_MAX = DRIVE_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  q_valid,
   input  pfpc_kind_type         q_kind,
   input  logic [ADC_BITS-1:0]   q_adc,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DRIVE_W-1:0]    rsp_extend_drive,
   output logic [DRIVE_W-1:0]    rsp_retract_drive,
   output logic [LOAD_W-1:0]     rsp_sensed_load,
   output logic [CNT_W-1:0]      rsp_elapsed,
   output logic                  rsp_target_high,
   output logic [STATUS_W-1:0]   rsp_run_status
);

   localparam int LPROD_W = ADC_BITS + COEF_W;
   localparam int DPROD_W = LOAD_W + COEF_W;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCALE = 2'd1;
   localparam logic [1:0] S_GAIN  = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;

   // Configuration registers.
   logic [FORCE_W-1:0] target_force_ff;
   logic [CNT_W-1:0]   time_limit_ff;
   logic [CNT_W-1:0]   toggle_interval_ff;
   logic [COEF_W-1:0]  load_scale_ff;
   logic [COEF_W-1:0]  force_gain_ff;

   // Run state.
   logic [1:0]          state_ff, state_in;
   logic [CNT_W-1:0]    interval_ff, interval_in;
   logic [CNT_W-1:0]    elapsed_ff, elapsed_in;
   logic                phase_ff, phase_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [LOAD_W-1:0]   last_load_ff, last_load_in;

   // Datapath registers.
   logic [LPROD_W-1:0] load_prod_ff, load_prod_in;
   logic [LOAD_W-1:0]  mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [DPROD_W-1:0] drive_prod_ff, drive_prod_in;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DRIVE_W-1:0]  extend_ff, extend_in;
   logic [DRIVE_W-1:0]  retract_ff, retract_in;
   logic [LOAD_W-1:0]   sensed_ff, sensed_in;
   logic [CNT_W-1:0]    out_elapsed_ff, out_elapsed_in;
   logic                out_phase_ff, out_phase_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;

   logic                out_free;
   logic                emit;
   logic [CNT_W-1:0]    interval_inc;
   logic [CNT_W-1:0]    elapsed_inc;
   logic [LPROD_W-1:0]  load_shift;
   logic [LOAD_W-1:0]   load_sat;
   logic [LOAD_W-1:0]   target_val;
   logic [DPROD_W-1:0]  drive_shift;
   logic [DRIVE_W-1:0]  drive_sat;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         target_force_ff    <= '0;
         time_limit_ff      <= '0;
         toggle_interval_ff <= '0;
         load_scale_ff      <= '0;
         force_gain_ff      <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_TARGET_FORCE:    target_force_ff    <= csr_wdata[FORCE_W-1:0];
            REG_TIME_LIMIT:      time_limit_ff      <= csr_wdata[CNT_W-1:0];
            REG_TOGGLE_INTERVAL: toggle_interval_ff <= csr_wdata[CNT_W-1:0];
            REG_LOAD_SCALE:      load_scale_ff      <= csr_wdata[COEF_W-1:0];
            REG_FORCE_GAIN:      force_gain_ff      <= csr_wdata[COEF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // The output register can take a word when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Saturating counter increments for a tick.
   assign interval_inc = (interval_ff == {CNT_W{1'b1}}) ? interval_ff : interval_ff + 1'b1;
   assign elapsed_inc  = (elapsed_ff == {CNT_W{1'b1}}) ? elapsed_ff : elapsed_ff + 1'b1;

   // Scaled load, Q6.10 truncated, clamped to the load range.
   assign load_shift = load_prod_ff >> 10;
   assign load_sat   = (load_shift > LPROD_W'(LOAD_MAX)) ? LOAD_MAX : load_shift[LOAD_W-1:0];
   assign target_val = phase_ff ? LOAD_W'(target_force_ff) : '0;

   // Drive magnitude, Q8.8 truncated, clamped for either sign of the error.
   assign drive_shift = drive_prod_ff >> 8;
   assign drive_sat   = (drive_shift > DPROD_W'(DRIVE_MAX)) ? DRIVE_W'(DRIVE_MAX)
                                                            : drive_shift[DRIVE_W-1:0];

   // Sequencer: simple words finish on the pop cycle, running samples go
   // through the two multiplies before they are emitted.
   always_comb begin
      state_in      = state_ff;
      interval_in   = interval_ff;
      elapsed_in    = elapsed_ff;
      phase_in      = phase_ff;
      status_in     = status_ff;
      last_load_in  = last_load_ff;
      load_prod_in  = load_prod_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      drive_prod_in = drive_prod_ff;
      q_pop         = 1'b0;
      emit          = 1'b0;
      extend_in     = extend_ff;
      retract_in    = retract_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid && out_free) begin
               q_pop      = 1'b1;
               extend_in  = '0;
               retract_in = '0;
               if (q_kind.sample && status_ff == ST_RUN) begin
                  load_prod_in = LPROD_W'(q_adc) * LPROD_W'(load_scale_ff);
                  state_in     = S_SCALE;
               end else begin
                  emit = 1'b1;
                  if (q_kind.tick && status_ff == ST_RUN) begin
                     interval_in = interval_inc;
                     elapsed_in  = elapsed_inc;
                     if (interval_inc >= toggle_interval_ff) begin
                        phase_in    = !phase_ff;
                        interval_in = '0;
                     end
                     if (elapsed_inc >= time_limit_ff) begin
                        status_in = ST_DONE;
                     end
                  end else if (q_kind.stop) begin
                     status_in = ST_ESTOP;
                  end else if (q_kind.start) begin
                     interval_in = '0;
                     elapsed_in  = '0;
                     phase_in    = 1'b1;
                     status_in   = (time_limit_ff == '0) ? ST_DONE : ST_RUN;
                  end
               end
            end
         end
         S_SCALE: begin
            last_load_in = load_sat;
            neg_in       = (load_sat > target_val);
            mag_in       = (load_sat > target_val) ? load_sat - target_val
                                                   : target_val - load_sat;
            state_in     = S_GAIN;
         end
         S_GAIN: begin
            drive_prod_in = DPROD_W'(mag_ff) * DPROD_W'(force_gain_ff);
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               emit       = 1'b1;
               extend_in  = neg_ff ? '0 : drive_sat;
               retract_in = neg_ff ? drive_sat : '0;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Output register next values.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      sensed_in      = sensed_ff;
      out_elapsed_in = out_elapsed_ff;
      out_phase_in   = out_phase_ff;
      out_status_in  = out_status_ff;
      if (emit) begin
         rsp_valid_in   = 1'b1;
         sensed_in      = last_load_in;
         out_elapsed_in = elapsed_in;
         out_phase_in   = phase_in;
         out_status_in  = status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         interval_ff  <= '0;
         elapsed_ff   <= '0;
         phase_ff     <= 1'b1;
         status_ff    <= ST_IDLE;
         last_load_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         interval_ff  <= interval_in;
         elapsed_ff   <= elapsed_in;
         phase_ff     <= phase_in;
         status_ff    <= status_in;
         last_load_ff <= last_load_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      load_prod_ff   <= load_prod_in;
      mag_ff         <= mag_in;
      neg_ff         <= neg_in;
      drive_prod_ff  <= drive_prod_in;
      extend_ff      <= extend_in;
      retract_ff     <= retract_in;
      sensed_ff      <= sensed_in;
      out_elapsed_ff <= out_elapsed_in;
      out_phase_ff   <= out_phase_in;
      out_status_ff  <= out_status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_extend_drive  = extend_ff;
   assign rsp_retract_drive = retract_ff;
   assign rsp_sensed_load   = sensed_ff;
   assign rsp_elapsed       = out_elapsed_ff;
   assign rsp_target_high   = out_phase_ff;
   assign rsp_run_status    = out_status_ff;

endmodule

### src/press_force_p_controller_unit.sv
`timescale 1ns / 1ps

// Proportional press force regulator.
// Input channel (req_): one word per start, tick, sample or emergency stop,
// with the converter reading in req_adc_sample. Result channel (rsp_): one
// word for every input word, carrying the extend and retract drives, the
// latest scaled load, the elapsed tick count, the target phase and the status.
// Configuration (csr_): write-only registers, to be written while the block is
// idle; the block does not enforce this. Words enter a two-entry queue, so up
// to two words are taken while the result side is stalled. Start, tick, stop
// and samples outside a run go from the queue to the result register, one word
// per cycle unless the result is stalled. A sample in a run passes through pop
// and scale multiply, load clamp and error, gain multiply and drive clamp in
// order, and no other word is popped meanwhile. A stalled result holds its
// value and the sequencer waits on it; the queue then fills and raises req_stall.
// Reset clears the run state (idle, target phase high, counters and load zero)
// and all configuration registers, and empties the queue.
module press_force_p_controller_unit
   import pfpc_pkg::*;
#(
   parameter int ADC_BITS  = ADC_BITS_DEF,
   parameter int DRIVE_MAX = DRIVE_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [ADC_BITS-1:0]   req_adc_sample,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DRIVE_W-1:0]    rsp_extend_drive,
   output logic [DRIVE_W-1:0]    rsp_retract_drive,
   output logic [LOAD_W-1:0]     rsp_sensed_load,
   output logic [CNT_W-1:0]      rsp_elapsed,
   output logic                  rsp_target_high,
   output logic [STATUS_W-1:0]   rsp_run_status
);

   logic                q_valid;
   pfpc_kind_type       q_kind;
   logic [ADC_BITS-1:0] q_adc;
   logic                q_pop;

   // Front: takes and decodes words into the queue.
   pfpc_front #(
      .ADC_BITS (ADC_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_adc_sample (req_adc_sample),
      .q_valid        (q_valid),
      .q_kind         (q_kind),
      .q_adc          (q_adc),
      .q_pop          (q_pop)
   );

   // Back: run state, arithmetic and the result register.
   pfpc_back #(
      .ADC_BITS  (ADC_BITS),
      .DRIVE_MAX (DRIVE_MAX)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .q_valid           (q_valid),
      .q_kind            (q_kind),
      .q_adc             (q_adc),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_extend_drive  (rsp_extend_drive),
      .rsp_retract_drive (rsp_retract_drive),
      .rsp_sensed_load   (rsp_sensed_load),
      .rsp_elapsed       (rsp_elapsed),
      .rsp_target_high   (rsp_target_high),
      .rsp_run_status    (rsp_run_status)
   );

endmodule

### src/pfpc_checker.sv
`timescale 1ns / 1ps

module pfpc_checker
   import pfpc_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [DRIVE_W-1:0]  rsp_extend_drive,
   input logic [DRIVE_W-1:0]  rsp_retract_drive,
   input logic [LOAD_W-1:0]   rsp_sensed_load,
   input logic [CNT_W-1:0]    rsp_elapsed,
   input logic                rsp_target_high,
   input logic [STATUS_W-1:0] rsp_run_status
);

   // Only one drive channel is ever active.
   a_one_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_extend_drive == '0 || rsp_retract_drive == '0))
      else $error("both drive channels active");

   // Outside a run both drives are zero.
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_run_status != ST_RUN) |->
         (rsp_extend_drive == '0 && rsp_retract_drive == '0))
      else $error("drive active while not running");

   // A stalled result word holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_extend_drive)
         && $stable(rsp_retract_drive) && $stable(rsp_sensed_load)
         && $stable(rsp_elapsed) && $stable(rsp_target_high)
         && $stable(rsp_run_status)))
      else $error("stalled result word changed");

   // No result word directly after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind press_force_p_controller_unit pfpc_checker u_pfpc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_extend_drive  (rsp_extend_drive),
   .rsp_retract_drive (rsp_retract_drive),
   .rsp_sensed_load   (rsp_sensed_load),
   .rsp_elapsed       (rsp_elapsed),
   .rsp_target_high   (rsp_target_high),
   .rsp_run_status    (rsp_run_status)
);
